// ===== design/triangle_edge_crossing_test_top_macros.svh =====
// Assertion macros shared by the triangle crossing test checker
`ifndef TRIANGLE_EDGE_CROSSING_TEST_TOP_MACROS_SVH
`define TRIANGLE_EDGE_CROSSING_TEST_TOP_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define TECT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define TECT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset
`define TECT_ASSERT_NEXT_ANY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tect_pkg.sv =====
// Types and constants of the triangle edge crossing test
`timescale 1ns / 1ps

package tect_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;

    // Following vertex around a triangle
    localparam int NEXT_VERT [3] = '{1, 2, 0};

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    typedef struct packed {
        t_coord tri_a_x0;
        t_coord tri_a_y0;
        t_coord tri_a_x1;
        t_coord tri_a_y1;
        t_coord tri_a_x2;
        t_coord tri_a_y2;
        t_coord tri_b_x0;
        t_coord tri_b_y0;
        t_coord tri_b_x1;
        t_coord tri_b_y1;
        t_coord tri_b_x2;
        t_coord tri_b_y2;
    } t_tri_pair;

    typedef struct packed {
        logic collide;
    } t_result;

endpackage

// ===== design/tect_if.sv =====
// Valid/ready stream interfaces for triangle pairs and results
`timescale 1ns / 1ps

interface tect_in_if;
    import tect_pkg::*;

    logic      valid;
    logic      ready;
    t_tri_pair data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tect_out_if;
    import tect_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/triangle_edge_crossing_test_top.sv =====
// Triangle pair edge crossing test: four-stage pipeline, top level
`timescale 1ns / 1ps

// Takes one triangle pair per cycle while the output side is not stalled, and
// returns collide from the stage 4 result register. Stage 1 forms the edge and
// vertex differences and the 9 vertex equality checks, stage 2 holds the 36
// 17x17 signed multipliers (two per orientation determinant, 18 determinants
// shared by all 9 cross-triangle edge pairs), stage 3 does the wide compares,
// stage 4 combines them into the result register. Each stage stalls only when
// it holds data that the next stage cannot take, so bubbles are squeezed out.
// Edges within one triangle always share a vertex and so are never tested.
module triangle_edge_crossing_test_top (
    input logic        i_clk,
    input logic        i_rst_n,
    tect_in_if.sink    i_in,
    tect_out_if.source o_out
);
    import tect_pkg::*;

    // [triangle][vertex]
    t_coord w_px [2][3];
    t_coord w_py [2][3];

    // Determinant index [s][i][k]: edge i of triangle s against vertex k of
    // the other triangle, pivot at the edge start.
    t_diff n_dx1 [2][3][3];
    t_diff n_dy1 [2][3][3];
    t_diff n_dx2 [2][3][3];
    t_diff n_dy2 [2][3][3];
    t_diff r_dx1 [2][3][3];
    t_diff r_dy1 [2][3][3];
    t_diff r_dx2 [2][3][3];
    t_diff r_dy2 [2][3][3];

    t_prod n_lhs [2][3][3];
    t_prod n_rhs [2][3][3];
    t_prod r_lhs [2][3][3];
    t_prod r_rhs [2][3][3];

    logic n_pos [2][3][3];
    logic r_pos [2][3][3];

    // [vertex of a][vertex of b]
    logic n_eq  [3][3];
    logic r_eq1 [3][3];
    logic r_eq2 [3][3];
    logic r_eq3 [3][3];

    logic n_collide;
    logic r_collide;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4 = !r_v4 || o_out.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_in.ready         = w_en1;
    assign o_out.valid        = r_v4;
    assign o_out.data.collide = r_collide;

    always_comb begin
        w_px[0][0] = i_in.data.tri_a_x0;
        w_py[0][0] = i_in.data.tri_a_y0;
        w_px[0][1] = i_in.data.tri_a_x1;
        w_py[0][1] = i_in.data.tri_a_y1;
        w_px[0][2] = i_in.data.tri_a_x2;
        w_py[0][2] = i_in.data.tri_a_y2;
        w_px[1][0] = i_in.data.tri_b_x0;
        w_py[1][0] = i_in.data.tri_b_y0;
        w_px[1][1] = i_in.data.tri_b_x1;
        w_py[1][1] = i_in.data.tri_b_y1;
        w_px[1][2] = i_in.data.tri_b_x2;
        w_py[1][2] = i_in.data.tri_b_y2;
    end

    // Stage 1: differences, exact at one bit wider than the coordinates
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    n_dx1[s][i][k] = t_diff'(w_px[s][NEXT_VERT[i]]) - t_diff'(w_px[s][i]);
                    n_dy1[s][i][k] = t_diff'(w_py[s][NEXT_VERT[i]]) - t_diff'(w_py[s][i]);
                    n_dx2[s][i][k] = t_diff'(w_px[1-s][k]) - t_diff'(w_px[s][i]);
                    n_dy2[s][i][k] = t_diff'(w_py[1-s][k]) - t_diff'(w_py[s][i]);
                end
            end
        end
        for (int m = 0; m < 3; m++) begin
            for (int n = 0; n < 3; n++) begin
                n_eq[m][n] = (w_px[0][m] == w_px[1][n]) && (w_py[0][m] == w_py[1][n]);
            end
        end
    end

    // Stage 2: cross product terms
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    n_lhs[s][i][k] = r_dy2[s][i][k] * r_dx1[s][i][k];
                    n_rhs[s][i][k] = r_dy1[s][i][k] * r_dx2[s][i][k];
                end
            end
        end
    end

    // Stage 3: strict counter-clockwise sign
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    n_pos[s][i][k] = r_lhs[s][i][k] > r_rhs[s][i][k];
                end
            end
        end
    end

    // Stage 4: edge i of a against edge j of b. The determinant is cyclic, so
    // ccw(a_i, b_j, b_j+1) is the same sign as ccw(b_j, b_j+1, a_i).
    always_comb begin
        logic share;
        logic side_a;
        logic side_b;
        n_collide = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                share  = r_eq3[i][j] || r_eq3[i][NEXT_VERT[j]] ||
                         r_eq3[NEXT_VERT[i]][j] || r_eq3[NEXT_VERT[i]][NEXT_VERT[j]];
                side_a = r_pos[1][j][i] != r_pos[1][j][NEXT_VERT[i]];
                side_b = r_pos[0][i][j] != r_pos[0][i][NEXT_VERT[j]];
                if (!share && side_a && side_b) begin
                    n_collide = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_in.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_dx1 <= n_dx1;
            r_dy1 <= n_dy1;
            r_dx2 <= n_dx2;
            r_dy2 <= n_dy2;
            r_eq1 <= n_eq;
        end
        if (w_en2) begin
            r_lhs <= n_lhs;
            r_rhs <= n_rhs;
            r_eq2 <= r_eq1;
        end
        if (w_en3) begin
            r_pos <= n_pos;
            r_eq3 <= r_eq2;
        end
        if (w_en4) begin
            r_collide <= n_collide;
        end
    end

endmodule

// ===== design/tect_checker.sv =====
// Port-level checker for the triangle crossing test, bound to the top level
`timescale 1ns / 1ps
`include "triangle_edge_crossing_test_top_macros.svh"

module tect_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_collide
);

    // A stalled result stays put
    `TECT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_collide), "result changed while stalled")

    // Reset empties the pipeline
    `TECT_ASSERT_NEXT_ANY(a_reset_empty, !i_rst_n, !i_out_valid, "result valid straight after reset")

    // A free output side never back-pressures the input
    `TECT_ASSERT_NOW(a_ready_flow, i_out_ready, i_in_ready, "input stalled while output is free")

    // Input is refused only when a result is waiting
    `TECT_ASSERT_NOW(a_full_stall, !i_in_ready, i_out_valid && !i_out_ready, "input stalled without a waiting result")

endmodule

bind triangle_edge_crossing_test_top tect_checker u_tect_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_collide (o_out.data.collide)
);

// ===== tb/sv/triangle_edge_crossing_test_top_tb.sv =====
// Self-checking testbench for the triangle pair edge crossing test
`timescale 1ns / 1ps

module triangle_edge_crossing_test_top_tb;
    import tect_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int MAX_IDLE       = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_ITEMS = 40;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 100;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 200000;

    // Expected collide column of the directed table
    localparam int TAB_CLEAR   = 0;
    localparam int TAB_HIT     = 1;
    localparam int TAB_PREDICT = -1;

    localparam int DIRECTED_ROWS = 20;

    // a: x0 y0 x1 y1 x2 y2, b: x0 y0 x1 y1 x2 y2
    localparam int DIRECTED_COORDS [DIRECTED_ROWS][12] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-32768, -32768, -32768, -32768, -32768, -32768,
          -32768, -32768, -32768, -32768, -32768, -32768},
        '{32767, 32767, 32767, 32767, 32767, 32767,
          32767, 32767, 32767, 32767, 32767, 32767},
        '{32767, -32768, 32767, -32768, 32767, -32768,
          -32768, 32767, -32768, 32767, -32768, 32767},
        '{0, 0, 10, 0, 5, 9, 0, 6, 10, 6, 5, -3},
        '{0, 0, 5, 9, 10, 0, 0, 6, 5, -3, 10, 6},
        '{0, 0, 1, 0, 0, 1, 100, 100, 101, 100, 100, 101},
        '{-100, -100, 100, -100, 0, 100, -1, -1, 1, -1, 0, 1},
        '{-1, -1, 1, -1, 0, 1, -100, -100, 100, -100, 0, 100},
        '{-32768, -32768, 32767, -32768, 0, 32767,
          -32768, 32767, 32767, 32767, 0, -32768},
        '{0, 0, 10, 0, 0, 10, 5, 0, 5, -5, 8, -5},
        '{0, 0, 10, 0, 0, 10, 5, 0, 15, 0, 10, -5},
        '{0, 0, 10, 0, 5, 5, 2, 0, 8, 0, 5, -5},
        '{0, 0, 10, 0, 5, 9, 0, 0, 10, 6, 5, -3},
        '{3, 4, -7, 2, 5, -9, 3, 4, -7, 2, 5, -9},
        '{1, 2, 7, 3, 4, 8, 7, 3, 4, 8, 1, 2},
        '{0, 0, 10, 10, 5, 5, 0, 10, 10, 0, 0, 10},
        '{21845, -21846, -21846, 21845, 21845, 21845,
          -21846, -21846, 21845, -21846, -21846, 21845},
        '{-32768, 0, 32767, 1, 32767, 0, 0, -32768, 1, 32767, 0, 32767},
        '{-1, -1, 1, -1, 0, 1, -1, 1, 1, 1, 0, -1}
    };

    localparam int DIRECTED_COLLIDE [DIRECTED_ROWS] = '{
        TAB_CLEAR, TAB_CLEAR, TAB_CLEAR, TAB_CLEAR, TAB_HIT,
        TAB_HIT, TAB_CLEAR, TAB_CLEAR, TAB_CLEAR, TAB_HIT,
        TAB_PREDICT, TAB_PREDICT, TAB_PREDICT, TAB_PREDICT, TAB_CLEAR,
        TAB_CLEAR, TAB_PREDICT, TAB_PREDICT, TAB_PREDICT, TAB_HIT
    };

    typedef enum int {
        FULL_RANGE,
        SMALL_GRID,
        MEDIUM_SPAN,
        EXTREME_PICK,
        SCALED_GRID,
        SHARED_VERTEX
    } t_coord_style;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tect_in_if  in_if ();
    tect_out_if out_if ();

    logic collide_expected [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    bit   tx_gapless     = 1'b0;
    bit   rx_gapless     = 1'b0;
    bit   sink_hold_req  = 1'b0;
    bit   sink_holding   = 1'b0;

    triangle_edge_crossing_test_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Strict left turn of c seen along a -> b, exact at 64 bits
    function automatic bit left_of(input longint ax, input longint ay,
                                   input longint bx, input longint by,
                                   input longint cx, input longint cy);
        return (cy - ay) * (bx - ax) > (by - ay) * (cx - ax);
    endfunction

    function automatic logic predict_collide(input t_tri_pair pair);
        longint px [6];
        longint py [6];
        longint ex [6][2];
        longint ey [6][2];
        logic   shared;
        logic   hit;
        hit = 1'b0;
        for (int v = 0; v < 6; v++) begin
            px[v] = longint'(t_coord'(pair[(11 - 2 * v) * 16 +: 16]));
            py[v] = longint'(t_coord'(pair[(10 - 2 * v) * 16 +: 16]));
        end
        for (int i = 0; i < 3; i++) begin
            ex[i][0]     = px[i];
            ey[i][0]     = py[i];
            ex[i][1]     = px[(i + 1) % 3];
            ey[i][1]     = py[(i + 1) % 3];
            ex[i + 3][0] = px[3 + i];
            ey[i + 3][0] = py[3 + i];
            ex[i + 3][1] = px[3 + (i + 1) % 3];
            ey[i + 3][1] = py[3 + (i + 1) % 3];
        end
        for (int i = 0; i < 6; i++) begin
            for (int j = i + 1; j < 6; j++) begin
                shared = 1'b0;
                for (int m = 0; m < 2; m++)
                    for (int n = 0; n < 2; n++)
                        if (ex[i][m] == ex[j][n] && ey[i][m] == ey[j][n])
                            shared = 1'b1;
                if (!shared &&
                    left_of(ex[i][0], ey[i][0], ex[j][0], ey[j][0], ex[j][1], ey[j][1]) !=
                    left_of(ex[i][1], ey[i][1], ex[j][0], ey[j][0], ex[j][1], ey[j][1]) &&
                    left_of(ex[i][0], ey[i][0], ex[i][1], ey[i][1], ex[j][0], ey[j][0]) !=
                    left_of(ex[i][0], ey[i][0], ex[i][1], ey[i][1], ex[j][1], ey[j][1]))
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_tri_pair random_pair();
        t_tri_pair    pair;
        t_coord_style style;
        int           v;
        int           scale;
        int           va;
        int           vb;
        int           extremes [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case ($urandom_range(0, 9))
            0, 1, 2: style = FULL_RANGE;
            3, 4:    style = SMALL_GRID;
            5:       style = MEDIUM_SPAN;
            6:       style = EXTREME_PICK;
            7:       style = SCALED_GRID;
            default: style = SHARED_VERTEX;
        endcase
        scale = $urandom_range(1, 8191);
        for (int k = 0; k < 12; k++) begin
            case (style)
                FULL_RANGE:   v = int'($urandom_range(0, 65535));
                SMALL_GRID:   v = int'($urandom_range(0, 8)) - 4;
                MEDIUM_SPAN:  v = int'($urandom_range(0, 400)) - 200;
                EXTREME_PICK: v = extremes[$urandom_range(0, 6)];
                SCALED_GRID:  v = (int'($urandom_range(0, 8)) - 4) * scale;
                default:      v = int'($urandom_range(0, 40)) - 20;
            endcase
            pair[(11 - k) * 16 +: 16] = 16'(v);
        end
        // copy one vertex of the first triangle onto the second
        if (style == SHARED_VERTEX) begin
            va = $urandom_range(0, 2);
            vb = $urandom_range(3, 5);
            pair[(11 - 2 * vb) * 16 +: 16] = pair[(11 - 2 * va) * 16 +: 16];
            pair[(10 - 2 * vb) * 16 +: 16] = pair[(10 - 2 * va) * 16 +: 16];
        end
        return pair;
    endfunction

    task automatic offer_pair(input t_tri_pair pair, input logic collide_due);
        int gap;
        gap = tx_gapless ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= pair;
        do @(posedge i_clk); while (!in_if.ready);
        collide_expected.push_back(collide_due);
    endtask

    task automatic idle_until_drained();
        in_if.valid <= 1'b0;
        while (collide_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: random stall per transfer, or one long hold-off on request
    initial begin : result_sink
        int stall;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                sink_holding  = 1'b1;
                stall         = HOLD_CYCLES;
            end else begin
                stall = rx_gapless ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                sink_holding = 1'b0;
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid && !sink_hold_req);
        end
    end

    always @(posedge i_clk) begin : result_check
        logic collide_due;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (collide_expected.size() == 0) begin
                $error("collide: no transfer expected, actual %0b", out_if.data.collide);
                mismatch_count++;
            end else begin
                collide_due = collide_expected.pop_front();
                if (out_if.data.collide !== collide_due) begin
                    $error("collide: expected %0b, actual %0b",
                           collide_due, out_if.data.collide);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("triangle_edge_crossing_test_top_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_tri_pair pair;
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int k = 0; k < 12; k++)
                pair[(11 - k) * 16 +: 16] = 16'(DIRECTED_COORDS[r][k]);
            offer_pair(pair, DIRECTED_COLLIDE[r] == TAB_PREDICT ?
                       predict_collide(pair) : DIRECTED_COLLIDE[r] == TAB_HIT);
        end
        idle_until_drained();

        // back-pressure: sink holds off while the source keeps streaming
        sink_hold_req = 1'b1;
        wait (sink_holding);
        tx_gapless = 1'b1;
        for (int n = 0; n < PRESSURE_ITEMS; n++) begin
            pair = random_pair();
            offer_pair(pair, predict_collide(pair));
        end
        tx_gapless = 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tx_gapless = (ph % 4 == 1) || (ph % 4 == 2);
            rx_gapless = (ph % 4 == 1) || (ph % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pair = random_pair();
                offer_pair(pair, predict_collide(pair));
            end
            if (ph % 3 == 2)
                idle_until_drained();
        end

        idle_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("triangle_edge_crossing_test_top_tb: PASS");
        else
            $display("triangle_edge_crossing_test_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/tect_pkg.sv
design/tect_if.sv
design/triangle_edge_crossing_test_top.sv
design/tect_checker.sv
tb/sv/triangle_edge_crossing_test_top_tb.sv
